>>> rtl/fpct_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fpct_pkg: shared types and constants for the frustum plane cull test
// Mode and state codes, evaluation step codes and datapath widths.
// ----------------------------------------------------------------------------
package fpct_pkg;

    localparam int MAX_PLANES_DEF = 8;
    localparam int ARG_W          = 32;
    localparam int PLANE_W        = 4 * ARG_W;
    localparam int PROD_W         = 2 * ARG_W;
    localparam int ACC_W          = PROD_W + 3;
    localparam int FRAC_W         = 16;
    localparam int COUNT_W        = 4;
    localparam int MODE_W         = 2;
    localparam int SLOT_W         = 3;

    localparam logic [COUNT_W-1:0] PLANE_COUNT_RST = COUNT_W'(6);

    typedef enum logic [MODE_W-1:0] {
        MODE_LOAD   = 2'd0,
        MODE_BOX    = 2'd1,
        MODE_SPHERE = 2'd2,
        MODE_RSVD   = 2'd3
    } mode_t;

    typedef enum logic [1:0] {
        ST_IDLE   = 2'd0,
        ST_RUN    = 2'd1,
        ST_CHECK  = 2'd2,
        ST_RESULT = 2'd3
    } state_t;

    typedef enum logic [1:0] {
        STEP_X   = 2'd0,
        STEP_Y   = 2'd1,
        STEP_Z   = 2'd2,
        STEP_SUM = 2'd3
    } step_t;

    typedef struct packed {
        logic  run;
        step_t step;
    } eval_ctrl_t;

endpackage : fpct_pkg
`default_nettype wire

>>> rtl/fpct_eval.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fpct_eval: plane store and shared multiply-accumulate unit
// Holds the clipping planes and evaluates one plane over several steps with
// one multiplier and one adder; flags a failing plane value.
// ----------------------------------------------------------------------------
module fpct_eval #(
    parameter  int MAX_PLANES = fpct_pkg::MAX_PLANES_DEF,
    localparam int ADDR_W     = (MAX_PLANES > 1) ? $clog2(MAX_PLANES) : 1
) (
    input  wire logic                                 clk,
    input  wire logic                                 wr_en,
    input  wire logic [ADDR_W-1:0]                    wr_addr,
    input  wire logic                                 cap_en,
    input  wire fpct_pkg::mode_t                      cap_mode,
    input  wire logic                                 cap_strict,
    input  wire logic signed [fpct_pkg::ARG_W-1:0]    arg_a,
    input  wire logic signed [fpct_pkg::ARG_W-1:0]    arg_b,
    input  wire logic signed [fpct_pkg::ARG_W-1:0]    arg_c,
    input  wire logic signed [fpct_pkg::ARG_W-1:0]    arg_d,
    input  wire logic signed [fpct_pkg::ARG_W-1:0]    arg_e,
    input  wire logic signed [fpct_pkg::ARG_W-1:0]    arg_f,
    input  wire logic [ADDR_W-1:0]                    rd_addr,
    input  wire fpct_pkg::eval_ctrl_t                 ctrl,
    output logic                                      fail
);
    import fpct_pkg::*;

    logic [PLANE_W-1:0]        store_mem [MAX_PLANES];
    logic [PLANE_W-1:0]        plane_reg;

    logic signed [ARG_W-1:0]   lo_x_reg, lo_y_reg, lo_z_reg;
    logic signed [ARG_W-1:0]   hi_x_reg, hi_y_reg, hi_z_reg;
    logic signed [ACC_W-1:0]   extra_reg;
    logic                      strict_reg;

    logic signed [PROD_W-1:0]  prod_reg, prod_next;
    logic signed [ACC_W-1:0]   acc_reg, acc_next;

    logic signed [ARG_W-1:0]   coef, lo_v, hi_v, xsel;
    logic signed [ARG_W-1:0]   p_a, p_b, p_c, p_d;
    logic signed [ACC_W-1:0]   add_a, add_b;
    logic                      lo_le_hi;

    assign p_a = plane_reg[4*ARG_W-1:3*ARG_W];
    assign p_b = plane_reg[3*ARG_W-1:2*ARG_W];
    assign p_c = plane_reg[2*ARG_W-1:ARG_W];
    assign p_d = plane_reg[ARG_W-1:0];

    // plane store, registered read
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            store_mem[wr_addr] <= {arg_a, arg_b, arg_c, arg_d};
        end
        plane_reg <= store_mem[rd_addr];
    end

    // operands of the item under test
    always_ff @(posedge clk)
    begin
        if (cap_en)
        begin
            strict_reg <= cap_strict;
            lo_x_reg   <= arg_a;
            lo_y_reg   <= arg_b;
            lo_z_reg   <= arg_c;
            if (cap_mode == MODE_BOX)
            begin
                hi_x_reg  <= arg_d;
                hi_y_reg  <= arg_e;
                hi_z_reg  <= arg_f;
                extra_reg <= '0;
            end
            else
            begin
                hi_x_reg  <= arg_a;
                hi_y_reg  <= arg_b;
                hi_z_reg  <= arg_c;
                extra_reg <= {{(ACC_W-ARG_W-FRAC_W){arg_d[ARG_W-1]}}, arg_d, {FRAC_W{1'b0}}};
            end
        end
    end

    // per axis: the corner that minimizes coef * x
    always_comb
    begin
        unique case (ctrl.step)
            STEP_X:
            begin
                coef = p_a;
                lo_v = lo_x_reg;
                hi_v = hi_x_reg;
            end
            STEP_Y:
            begin
                coef = p_b;
                lo_v = lo_y_reg;
                hi_v = hi_y_reg;
            end
            STEP_Z:
            begin
                coef = p_c;
                lo_v = lo_z_reg;
                hi_v = hi_z_reg;
            end
            default:
            begin
                coef = p_c;
                lo_v = lo_z_reg;
                hi_v = hi_z_reg;
            end
        endcase
        lo_le_hi = (lo_v <= hi_v);
        if (!coef[ARG_W-1])
        begin
            xsel = lo_le_hi ? lo_v : hi_v;
        end
        else
        begin
            xsel = lo_le_hi ? hi_v : lo_v;
        end
        prod_next = coef * xsel;
    end

    // shared adder: first step loads d plus the sphere radius term
    always_comb
    begin
        if (ctrl.step == STEP_X)
        begin
            add_a = extra_reg;
            add_b = {{(ACC_W-ARG_W-FRAC_W){p_d[ARG_W-1]}}, p_d, {FRAC_W{1'b0}}};
        end
        else
        begin
            add_a = acc_reg;
            add_b = {{(ACC_W-PROD_W){prod_reg[PROD_W-1]}}, prod_reg};
        end
        acc_next = add_a + add_b;
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.run)
        begin
            prod_reg <= prod_next;
            acc_reg  <= acc_next;
        end
    end

    assign fail = acc_reg[ACC_W-1] || (strict_reg && (acc_reg == '0));

endmodule : fpct_eval
`default_nettype wire

>>> rtl/frustum_plane_cull_test_top.sv
`timescale 1ns / 1ps
`default_nettype none
// load item: no result; ready again the next cycle
// test item: per plane walked, four multiply-accumulate steps on the
// shared unit plus one check, stopping at the first failing plane
// out_valid rises from the result state once any pending result is taken
// no active planes: straight to the result state, then back to idle
// rst_n async low: plane count 6, no result pending; planes must be loaded
// ----------------------------------------------------------------------------
// frustum_plane_cull_test_top: box and sphere culling against stored planes
// Sequences the plane store and shared evaluation unit, handles the item,
// configuration and result handshakes.
// ----------------------------------------------------------------------------
module frustum_plane_cull_test_top #(
    parameter int MAX_PLANES = fpct_pkg::MAX_PLANES_DEF
) (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 cfg_valid,
    output logic                                      cfg_ready,
    input  wire logic [fpct_pkg::COUNT_W-1:0]         cfg_data,
    input  wire logic                                 in_valid,
    output logic                                      in_ready,
    input  wire logic [fpct_pkg::MODE_W-1:0]          mode,
    input  wire logic                                 strict,
    input  wire logic [fpct_pkg::SLOT_W-1:0]          plane_slot,
    input  wire logic signed [fpct_pkg::ARG_W-1:0]    arg_a,
    input  wire logic signed [fpct_pkg::ARG_W-1:0]    arg_b,
    input  wire logic signed [fpct_pkg::ARG_W-1:0]    arg_c,
    input  wire logic signed [fpct_pkg::ARG_W-1:0]    arg_d,
    input  wire logic signed [fpct_pkg::ARG_W-1:0]    arg_e,
    input  wire logic signed [fpct_pkg::ARG_W-1:0]    arg_f,
    output logic                                      out_valid,
    input  wire logic                                 out_ready,
    output logic                                      inside_res
);
    import fpct_pkg::*;

    localparam int ADDR_W = (MAX_PLANES > 1) ? $clog2(MAX_PLANES) : 1;
    localparam int CNT_W  = $clog2(MAX_PLANES + 1);

    state_t              state_reg, state_next;
    step_t               step_reg, step_next;
    logic [CNT_W-1:0]    idx_reg, idx_next;
    logic [COUNT_W-1:0]  count_reg;
    logic                verdict_reg, verdict_next;
    logic                out_valid_reg, out_valid_next;
    logic                inside_reg, inside_next;

    logic [CNT_W-1:0]    n_act;
    logic                last_plane;
    logic                in_fire;
    logic                is_test;
    logic                wr_en;
    logic                fail;
    mode_t               in_mode;
    eval_ctrl_t          ctrl;

    assign in_mode = mode_t'(mode);
    assign in_fire = in_valid && in_ready;
    assign is_test = (in_mode == MODE_BOX) || (in_mode == MODE_SPHERE);

    always_comb
    begin
        if (32'(count_reg) > MAX_PLANES)
        begin
            n_act = CNT_W'(MAX_PLANES);
        end
        else
        begin
            n_act = CNT_W'(count_reg);
        end
    end

    assign last_plane = (CNT_W'(idx_reg + CNT_W'(1)) == n_act);

    // next state
    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        idx_next   = idx_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_fire && is_test)
                begin
                    idx_next   = '0;
                    step_next  = STEP_X;
                    state_next = (n_act == '0) ? ST_RESULT : ST_RUN;
                end
            end
            ST_RUN:
            begin
                if (step_reg == STEP_SUM)
                begin
                    state_next = ST_CHECK;
                end
                else
                begin
                    step_next = step_t'(step_reg + 2'd1);
                end
            end
            ST_CHECK:
            begin
                if (fail || last_plane)
                begin
                    state_next = ST_RESULT;
                end
                else
                begin
                    idx_next   = CNT_W'(idx_reg + CNT_W'(1));
                    step_next  = STEP_X;
                    state_next = ST_RUN;
                end
            end
            ST_RESULT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // outputs and result path
    always_comb
    begin
        in_ready       = (state_reg == ST_IDLE);
        cfg_ready      = 1'b1;
        wr_en          = in_fire && (in_mode == MODE_LOAD) && (32'(plane_slot) < MAX_PLANES);
        ctrl.run       = (state_reg == ST_RUN);
        ctrl.step      = step_reg;
        verdict_next   = verdict_reg;
        out_valid_next = out_valid_reg && !out_ready;
        inside_next    = inside_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    verdict_next = 1'b1;
                end
            end
            ST_CHECK:
            begin
                if (fail)
                begin
                    verdict_next = 1'b0;
                end
            end
            ST_RESULT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next = 1'b1;
                    inside_next    = verdict_reg;
                end
            end
            default:
            begin
                verdict_next = verdict_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            step_reg      <= STEP_X;
            idx_reg       <= '0;
            count_reg     <= PLANE_COUNT_RST;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                count_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        verdict_reg <= verdict_next;
        inside_reg  <= inside_next;
    end

    assign out_valid  = out_valid_reg;
    assign inside_res = inside_reg;

    fpct_eval #(
        .MAX_PLANES (MAX_PLANES)
    ) u_eval (
        .clk        (clk),
        .wr_en      (wr_en),
        .wr_addr    (ADDR_W'(plane_slot)),
        .cap_en     (in_fire),
        .cap_mode   (in_mode),
        .cap_strict (strict),
        .arg_a      (arg_a),
        .arg_b      (arg_b),
        .arg_c      (arg_c),
        .arg_d      (arg_d),
        .arg_e      (arg_e),
        .arg_f      (arg_f),
        .rd_addr    (idx_next[ADDR_W-1:0]),
        .ctrl       (ctrl),
        .fail       (fail)
    );

endmodule : frustum_plane_cull_test_top
`default_nettype wire

>>> rtl/fpct_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fpct_checker: port-level checks for the frustum plane cull test
// Watches the item and result handshakes of the top level over time.
// ----------------------------------------------------------------------------
module fpct_checker (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              in_valid,
    input  wire logic                              in_ready,
    input  wire logic [fpct_pkg::MODE_W-1:0]       mode,
    input  wire logic                              out_valid,
    input  wire logic                              out_ready,
    input  wire logic                              inside_res
);
    import fpct_pkg::*;

    // a pending result holds until taken
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(inside_res))
        else $error("result item changed while stalled");

    // a load item never stalls the input side
    a_load_ready: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && (mode == MODE_LOAD) |=> in_ready)
        else $error("not ready after load item");

    // a test item keeps the block busy
    a_test_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && ((mode == MODE_BOX) || (mode == MODE_SPHERE))
        |=> !in_ready)
        else $error("ready right after test item");

    // a new result only follows a busy cycle
    a_result_src: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> !$past(in_ready))
        else $error("result without a test in flight");

endmodule : fpct_checker

bind frustum_plane_cull_test_top fpct_checker u_fpct_checker (.*);
`default_nettype wire
